// File: design/bfws_pkg.sv
// Shared types, codes and bit helpers for the bit field word store.
package bfws_pkg;

  localparam int DEPTH     = 256;
  localparam int ADDR_W    = 8;
  localparam int WORD_BITS = 64;
  localparam int CFG_W     = 9;

  // access kinds
  localparam logic [1:0] KIND_WR_BITS  = 2'd0;
  localparam logic [1:0] KIND_RD_BITS  = 2'd1;
  localparam logic [1:0] KIND_WR_BYTES = 2'd2;
  localparam logic [1:0] KIND_RD_BYTES = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_BAD_LOC   = 2'd2;
  localparam logic [1:0] ST_BAD_START = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_READY = 2'd0;
  localparam logic [1:0] REG_WORDS = 2'd1;
  localparam logic [1:0] REG_WSIZE = 2'd2;

  typedef struct packed {
    logic       ready;
    logic [8:0] words;
    logic [6:0] wsize;
  } cfg_t;

  // decoded access, carried from accept to the read-modify-write stage
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic              rd_swap;
    logic [ADDR_W-1:0] loc;
    logic [6:0]        sh;
    logic [3:0]        nb;
    logic [63:0]       rmask;
    logic [63:0]       fld;
    logic [63:0]       fmask;
    logic [1:0]        status;
    logic              trunc;
  } req_t;

  function automatic logic [63:0] rev64(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[i] = x[63-i];
    end
    return r;
  endfunction

  function automatic logic [63:0] low_mask(input logic [6:0] n);
    return ~(~64'd0 << n);
  endfunction

  // reverse the order of the low nb bytes, clear the rest
  function automatic logic [63:0] swap_low(input logic [63:0] x, input logic [3:0] nb);
    logic [63:0] r;
    logic [6:0]  sh;
    for (int k = 0; k < 8; k++) begin
      r[k*8 +: 8] = x[(7-k)*8 +: 8];
    end
    sh = 7'd64 - {nb, 3'b000};
    return r >> sh;
  endfunction

endpackage

// File: design/bfws_decode.sv
// Request decode: checks, field length and shift, prepared write field.
module bfws_decode
  import bfws_pkg::*;
(
  input  cfg_t              cfg,
  input  logic [1:0]        kind,
  input  logic [ADDR_W-1:0] location,
  input  logic [5:0]        start_bit,
  input  logic [6:0]        length,
  input  logic [63:0]       value,
  input  logic              little_endian,
  output req_t              req
);

  logic [6:0]  ws;
  logic [6:0]  avail;
  logic [3:0]  room;
  logic [3:0]  nb;
  logic [6:0]  n;
  logic        trunc;
  logic        is_byte;
  logic        ok;
  logic [1:0]  status;
  logic [6:0]  sh;
  logic [63:0] mask;
  logic [63:0] wval;

  always_comb begin
    ws      = (cfg.wsize > 7'(WORD_BITS)) ? 7'(WORD_BITS) : cfg.wsize;
    avail   = ws - {1'b0, start_bit};
    room    = avail[6:3];
    is_byte = (kind == KIND_WR_BYTES) || (kind == KIND_RD_BYTES);
    nb      = 4'd0;
    trunc   = 1'b0;
    if (is_byte) begin
      if (length > {3'b000, room}) begin
        nb    = room;
        trunc = 1'b1;
      end else begin
        nb = length[3:0];
      end
      n = {nb, 3'b000};
    end else begin
      if (length > avail) begin
        n     = avail;
        trunc = 1'b1;
      end else begin
        n = length;
      end
    end

    priority if (!cfg.ready) begin
      status = ST_NOT_READY;
    end else if ({1'b0, location} >= cfg.words) begin
      status = ST_BAD_LOC;
    end else if ({1'b0, start_bit} >= ws) begin
      status = ST_BAD_START;
    end else begin
      status = ST_OK;
    end
    ok = (status == ST_OK);

    // field LSB sits at bit start_bit+n-1; in the reversed word it lands at sh
    sh   = 7'd64 - {1'b0, start_bit} - n;
    mask = low_mask(n);
    wval = (is_byte && little_endian) ? swap_low(value, nb) : value;

    req.wr_en   = ok && ((kind == KIND_WR_BITS) || (kind == KIND_WR_BYTES));
    req.rd_en   = ok && ((kind == KIND_RD_BITS) || (kind == KIND_RD_BYTES));
    req.rd_swap = is_byte && little_endian;
    req.loc     = location;
    req.sh      = sh;
    req.nb      = nb;
    req.rmask   = mask;
    req.fld     = rev64((wval & mask) << sh);
    req.fmask   = rev64(mask << sh);
    req.status  = status;
    req.trunc   = ok && trunc;
  end

endmodule

// File: design/bit_field_word_store.sv
// Top level: word memory with bit and byte field read-modify-write access.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  in       | start, busy               | kind, location, start_bit, length, value,
//           |                           | little_endian
//  out      | out_valid (one cycle)     | read_data, status, truncated
//  cfg      | cfg_we                    | cfg_index, cfg_wdata
//
// One access per cycle: the memory is read at accept, the word is modified and
// written back in the next cycle, and the result appears on the cycle after.
// A write to the same word in the previous cycle is forwarded. Reset clears
// per-word valid bits, so unwritten words read as zero; busy is high only
// while in reset. Results cannot be held off.
module bit_field_word_store
  import bfws_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_kind,
  input  logic [ADDR_W-1:0] in_location,
  input  logic [5:0]        in_start_bit,
  input  logic [6:0]        in_length,
  input  logic [63:0]       in_value,
  input  logic              in_little_endian,
  output logic              out_valid,
  output logic [63:0]       out_read_data,
  output logic [1:0]        out_status,
  output logic              out_truncated,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  cfg_t              cfg_r;
  logic              busy_r;
  logic              accept;
  req_t              req;
  req_t              s1_r;
  logic              s1_vld_r;
  logic [63:0]       mem [DEPTH];
  logic [DEPTH-1:0]  wvld_r;
  logic [63:0]       rd_data_r;
  logic              rd_vld_r;
  logic              fwd_en_r;
  logic [ADDR_W-1:0] fwd_loc_r;
  logic [63:0]       fwd_data_r;
  logic [63:0]       word;
  logic [63:0]       new_word;
  logic [63:0]       rdata;
  logic              out_valid_r;
  logic [63:0]       out_data_r;
  logic [1:0]        out_status_r;
  logic              out_trunc_r;

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ready <= 1'b0;
      cfg_r.words <= 9'd256;
      cfg_r.wsize <= 7'd64;
      busy_r      <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_READY: cfg_r.ready <= cfg_wdata[0];
          REG_WORDS: cfg_r.words <= cfg_wdata[8:0];
          REG_WSIZE: cfg_r.wsize <= cfg_wdata[6:0];
          default:   ;
        endcase
      end
    end
  end

  bfws_decode u_decode (
    .cfg           (cfg_r),
    .kind          (in_kind),
    .location      (in_location),
    .start_bit     (in_start_bit),
    .length        (in_length),
    .value         (in_value),
    .little_endian (in_little_endian),
    .req           (req)
  );

  // memory read at accept, write back from stage 1
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= mem[in_location];
      s1_r      <= req;
    end
    if (s1_vld_r && s1_r.wr_en) begin
      mem[s1_r.loc] <= new_word;
    end
    fwd_loc_r  <= s1_r.loc;
    fwd_data_r <= new_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r   <= '0;
      rd_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      fwd_en_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      fwd_en_r <= s1_vld_r && s1_r.wr_en;
      if (accept) begin
        rd_vld_r <= wvld_r[in_location];
      end
      if (s1_vld_r && s1_r.wr_en) begin
        wvld_r[s1_r.loc] <= 1'b1;
      end
    end
  end

  // take the word written last cycle when it is the one just read
  always_comb begin
    if (fwd_en_r && (fwd_loc_r == s1_r.loc)) begin
      word = fwd_data_r;
    end else if (rd_vld_r) begin
      word = rd_data_r;
    end else begin
      word = '0;
    end
    new_word = (word & ~s1_r.fmask) | s1_r.fld;
    rdata    = (rev64(word) >> s1_r.sh) & s1_r.rmask;
    if (s1_r.rd_swap) begin
      rdata = swap_low(rdata, s1_r.nb);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      out_data_r   <= s1_r.rd_en ? rdata : 64'd0;
      out_status_r <= s1_r.status;
      out_trunc_r  <= s1_r.trunc;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_status    = out_status_r;
  assign out_truncated = out_trunc_r;

endmodule
